@@ design/rau_pkg.sv @@
// shared types, constants and codes of the rational arithmetic unit
package rau_pkg;

  localparam int unsigned DefValueWidth = 32;
  localparam int unsigned FieldWidth    = 32;
  localparam int unsigned DenOutWidth   = 31;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // sequencer states of the top level
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_COMB,
    S_GCD_START,
    S_GCD_WAIT,
    S_QN_START,
    S_QN_WAIT,
    S_QD_START,
    S_QD_WAIT,
    S_CHECK,
    S_OUT
  } state_t;

  // divider states
  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } div_state_t;

  // request from the sequencer to the divider
  typedef struct packed {
    logic start;
    logic take;
  } div_ctrl_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/rau_if.sv @@
// valid/ready channel interfaces of the rational arithmetic unit
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic signed [rau_pkg::FieldWidth-1:0] left_num;
  logic signed [rau_pkg::FieldWidth-1:0] left_den;
  logic signed [rau_pkg::FieldWidth-1:0] right_num;
  logic signed [rau_pkg::FieldWidth-1:0] right_den;

  modport source (output valid, command, left_num, left_den, right_num, right_den,
                  input ready);
  modport sink (input valid, command, left_num, left_den, right_num, right_den,
                output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic signed [rau_pkg::FieldWidth-1:0]  result_num;
  logic        [rau_pkg::DenOutWidth-1:0] result_den;
  logic [1:0]  status;

  modport source (output valid, result_num, result_den, status, input ready);
  modport sink (input valid, result_num, result_den, status, output ready);
endinterface

@@ design/rau_divider.sv @@
// shared restoring divider, one quotient bit per cycle
module rau_divider #(
  parameter int unsigned W = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rau_pkg::div_ctrl_t   ctrl,
  input  logic [W-1:0]         dividend,
  input  logic [W-1:0]         divisor,
  output rau_pkg::div_stat_t   stat,
  output logic [W-1:0]         quotient,
  output logic [W-1:0]         remainder
);
  import rau_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  div_state_t   state_r, state_nxt;
  logic [W-1:0] q_r, q_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0]   trial;
  logic [W:0]   shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    shifted   = {rem_r, q_r[W-1]};
    trial     = shifted - {1'b0, dvs_r};
    unique case (state_r)
      D_IDLE: begin
        if (ctrl.start) begin
          q_nxt     = dividend;
          rem_nxt   = '0;
          dvs_nxt   = divisor;
          cnt_nxt   = CW'(W);
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        // shift in the next dividend bit, subtract when it fits
        if (!trial[W]) begin
          rem_nxt = trial[W-1:0];
          q_nxt   = {q_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[W-1:0];
          q_nxt   = {q_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = D_DONE;
        end
      end
      D_DONE: begin
        if (ctrl.take) begin
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  assign stat.busy  = (state_r != D_IDLE);
  assign stat.done  = (state_r == D_DONE);
  assign quotient   = q_r;
  assign remainder  = rem_r;

endmodule

@@ design/rational_arithmetic_unit_core.sv @@
// rational arithmetic unit top level: sequencer, shared multiplier and divider
//
//  channel | dir | beat contents
//  in_     | in  | command, left_num, left_den, right_num, right_den
//  out_    | out | result_num, result_den, status
//
// one item at a time; in_ready is high only while the sequencer is idle
// each Euclid step and each of the two reductions is one run of the
// shared 2*VALUE_WIDTH bit restoring divider
// errors found on the operands skip the arithmetic and go straight to S_OUT
// the result beat holds in its register while out_ready is low
// a finished item waits in S_OUT until the output register is free
// rst_n is synchronous and clears the sequencer and the output valid flag
module rational_arithmetic_unit_core #(
  parameter int unsigned VALUE_WIDTH = rau_pkg::DefValueWidth
) (
  input  logic   clk,
  input  logic   rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned WW = 2 * VW;
  localparam int unsigned FW = FieldWidth;

  state_t state_r, state_nxt;

  logic [1:0]    cmd_r, cmd_nxt;
  logic [VW-1:0] ma_r, da_r, mc_r, dc_r;
  logic [VW-1:0] ma_nxt, da_nxt, mc_nxt, dc_nxt;
  logic          sa_r, sc_r, sa_nxt, sc_nxt;
  logic [WW-1:0] x_r, y_r, den_r, mag_r;
  logic [WW-1:0] x_nxt, y_nxt, den_nxt, mag_nxt;
  logic          neg_r, neg_nxt;
  logic [WW-1:0] ga_r, gb_r, ga_nxt, gb_nxt;
  logic [WW-1:0] g_r, g_nxt;

  // finished result waiting for the output register
  logic signed [FW-1:0]  res_num_r, res_num_nxt;
  logic [DenOutWidth-1:0] res_den_r, res_den_nxt;
  status_t       res_st_r, res_st_nxt;

  logic signed [FW-1:0]  onum_r, onum_nxt;
  logic [DenOutWidth-1:0] oden_r, oden_nxt;
  status_t       ost_r, ost_nxt;
  logic          ovalid_r, ovalid_nxt;

  // shared multiplier operands
  logic [VW-1:0] mul_a, mul_b;
  logic [WW-1:0] mul_p;

  div_ctrl_t     dctrl;
  div_stat_t     dstat;
  logic [WW-1:0] div_n, div_d, div_q, div_r;

  // operand split into sign and magnitude
  function automatic logic [VW:0] split_fn(input logic [FW-1:0] raw);
    logic [VW-1:0] v;
    logic [VW-1:0] m;
    v = raw[VW-1:0];
    m = v[VW-1] ? (~v + 1'b1) : v;
    return {v[VW-1], m};
  endfunction

  logic [VW:0] sp_ln, sp_ld, sp_rn, sp_rd;
  assign sp_ln = split_fn(in_ch.left_num);
  assign sp_ld = split_fn(in_ch.left_den);
  assign sp_rn = split_fn(in_ch.right_num);
  assign sp_rd = split_fn(in_ch.right_den);

  assign mul_p = WW'(mul_a) * WW'(mul_b);

  rau_divider #(.W(WW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (dctrl),
    .dividend  (div_n),
    .divisor   (div_d),
    .stat      (dstat),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    ma_r      <= ma_nxt;
    da_r      <= da_nxt;
    mc_r      <= mc_nxt;
    dc_r      <= dc_nxt;
    sa_r      <= sa_nxt;
    sc_r      <= sc_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    den_r     <= den_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    ga_r      <= ga_nxt;
    gb_r      <= gb_nxt;
    g_r       <= g_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    res_st_r  <= res_st_nxt;
    onum_r    <= onum_nxt;
    oden_r    <= oden_nxt;
    ost_r     <= ost_nxt;
  end

  localparam logic [WW-1:0] Half = WW'(1) << (VW - 1);

  logic sy_w;
  logic [WW-1:0] signed_mag;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    ma_nxt      = ma_r;
    da_nxt      = da_r;
    mc_nxt      = mc_r;
    dc_nxt      = dc_r;
    sa_nxt      = sa_r;
    sc_nxt      = sc_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    den_nxt     = den_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    ga_nxt      = ga_r;
    gb_nxt      = gb_r;
    g_nxt       = g_r;
    res_num_nxt = res_num_r;
    res_den_nxt = res_den_r;
    res_st_nxt  = res_st_r;
    onum_nxt    = onum_r;
    oden_nxt    = oden_r;
    ost_nxt     = ost_r;
    ovalid_nxt  = ovalid_r;
    mul_a       = ma_r;
    mul_b       = dc_r;
    dctrl       = '0;
    div_n       = ga_r;
    div_d       = gb_r;
    sy_w        = 1'b0;
    signed_mag  = '0;
    in_ch.ready = 1'b0;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cmd_nxt = in_ch.command;
          ma_nxt  = sp_ln[VW-1:0];
          da_nxt  = sp_ld[VW-1:0];
          mc_nxt  = sp_rn[VW-1:0];
          dc_nxt  = sp_rd[VW-1:0];
          sa_nxt  = (sp_ln[VW] != sp_ld[VW]) && (sp_ln[VW-1:0] != '0);
          sc_nxt  = (sp_rn[VW] != sp_rd[VW]) && (sp_rn[VW-1:0] != '0);
          res_num_nxt = '0;
          res_den_nxt = '0;
          if (sp_ld[VW-1:0] == '0 || sp_rd[VW-1:0] == '0) begin
            res_st_nxt = ST_ZERO_DEN;
            state_nxt  = S_OUT;
          end else if (cmd_t'(in_ch.command) == CMD_DIV && sp_rn[VW-1:0] == '0) begin
            res_st_nxt = ST_DIV_ZERO;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        // first product: ma*dc, or ma*mc for multiply
        mul_a = ma_r;
        mul_b = (cmd_t'(cmd_r) == CMD_MUL) ? mc_r : dc_r;
        x_nxt = mul_p;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        mul_a = mc_r;
        mul_b = da_r;
        y_nxt = mul_p;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        // denominator: da*mc for divide, else da*dc
        mul_a = da_r;
        mul_b = (cmd_t'(cmd_r) == CMD_DIV) ? mc_r : dc_r;
        den_nxt = mul_p;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        if (cmd_t'(cmd_r) == CMD_ADD || cmd_t'(cmd_r) == CMD_SUB) begin
          sy_w = (cmd_t'(cmd_r) == CMD_SUB) ? !sc_r : sc_r;
          if (y_r == '0) sy_w = 1'b0;
          if (sa_r == sy_w) begin
            mag_nxt = x_r + y_r;
            neg_nxt = sa_r;
          end else if (x_r >= y_r) begin
            mag_nxt = x_r - y_r;
            neg_nxt = sa_r;
          end else begin
            mag_nxt = y_r - x_r;
            neg_nxt = sy_w;
          end
        end else begin
          mag_nxt = x_r;
          neg_nxt = sa_r != sc_r;
        end
        state_nxt = S_GCD_START;
      end
      S_GCD_START: begin
        if (mag_r == '0) begin
          res_num_nxt = '0;
          res_den_nxt = DenOutWidth'(1);
          res_st_nxt  = ST_OK;
          state_nxt   = S_OUT;
        end else begin
          ga_nxt    = mag_r;
          gb_nxt    = den_r;
          state_nxt = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: begin
        // one Euclid step per divider run
        if (gb_r == '0) begin
          g_nxt     = ga_r;
          state_nxt = S_QN_START;
        end else if (!dstat.busy) begin
          dctrl.start = 1'b1;
        end else if (dstat.done) begin
          dctrl.take = 1'b1;
          ga_nxt = gb_r;
          gb_nxt = div_r;
        end
      end
      S_QN_START: begin
        div_n = mag_r;
        div_d = g_r;
        dctrl.start = 1'b1;
        state_nxt = S_QN_WAIT;
      end
      S_QN_WAIT: begin
        if (dstat.done) begin
          dctrl.take = 1'b1;
          mag_nxt = div_q;
          state_nxt = S_QD_START;
        end
      end
      S_QD_START: begin
        div_n = den_r;
        div_d = g_r;
        dctrl.start = 1'b1;
        state_nxt = S_QD_WAIT;
      end
      S_QD_WAIT: begin
        if (dstat.done) begin
          dctrl.take = 1'b1;
          den_nxt = div_q;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        signed_mag = neg_r ? (~mag_r + 1'b1) : mag_r;
        if (den_r > Half - 1'b1 || (neg_r ? (mag_r > Half) : (mag_r > Half - 1'b1))) begin
          res_num_nxt = '0;
          res_den_nxt = '0;
          res_st_nxt  = ST_OVERFLOW;
        end else begin
          res_num_nxt = FW'(signed'(signed_mag[VW-1:0]));
          res_den_nxt = DenOutWidth'(den_r);
          res_st_nxt  = ST_OK;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // load once the previous beat has left or is leaving
        if (!ovalid_r || out_ch.ready) begin
          onum_nxt   = res_num_r;
          oden_nxt   = res_den_r;
          ost_nxt    = res_st_r;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_ch.valid      = ovalid_r;
  assign out_ch.result_num = onum_r;
  assign out_ch.result_den = oden_r;
  assign out_ch.status     = ost_r;

  // a new item is taken only with the sequencer idle
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> (state_r == S_IDLE))
    else $error("input beat taken while busy");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && ost_r != ST_OK) |-> (onum_r == '0 && oden_r == '0))
    else $error("error result with nonzero fields");

  // ok results have a positive denominator
  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && ost_r == ST_OK) |-> (oden_r != '0))
    else $error("ok result with zero denominator");

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ch.ready) |=> (ovalid_r && $stable(onum_r) && $stable(ost_r)))
    else $error("result changed under stall");

endmodule

@@ test/tb_rational_arithmetic_unit_core.sv @@
// testbench of the rational arithmetic unit: directed and random fraction beats, scoreboard check
module tb_rational_arithmetic_unit_core;
  import rau_pkg::*;

  localparam int unsigned VW        = 32;
  localparam int unsigned StallLimit = 60000;
  localparam int unsigned Drain     = 200;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    status_t            status;
  } fraction_res_t;

  class fraction_scoreboard;
    fraction_res_t pending[$];
    int unsigned   errors;

    function void split(input logic [31:0] v, output bit neg, output longint unsigned mag);
      logic [31:0] w;
      w   = v & 32'((64'd1 << VW) - 1);
      neg = w[VW-1];
      mag = neg ? ((64'd1 << VW) - 64'(w)) : 64'(w);
    endfunction

    function fraction_res_t reduce(cmd_t cmd, logic [31:0] ln, logic [31:0] ld,
                                   logic [31:0] rn, logic [31:0] rd);
      fraction_res_t     r;
      bit                n0, d0, n1, d1, sa, sc, sx, sy, neg;
      longint unsigned   ma, da, mc, dc, x, y, mag, den, g, a, b, t, half;
      r    = '{num: '0, den: '0, status: ST_OK};
      half = 64'd1 << (VW - 1);
      split(ln, n0, ma);
      split(ld, d0, da);
      split(rn, n1, mc);
      split(rd, d1, dc);
      if (da == 0 || dc == 0) begin
        r.status = ST_ZERO_DEN;
        return r;
      end
      if (cmd == CMD_DIV && mc == 0) begin
        r.status = ST_DIV_ZERO;
        return r;
      end
      sa = (n0 != d0) && ma != 0;
      sc = (n1 != d1) && mc != 0;
      case (cmd)
        CMD_ADD, CMD_SUB: begin
          x  = ma * dc;
          y  = mc * da;
          sx = sa;
          sy = (cmd == CMD_SUB) ? !sc : sc;
          if (y == 0) sy = 0;
          if (sx == sy) begin
            mag = x + y;
            neg = sx;
          end else if (x >= y) begin
            mag = x - y;
            neg = sx;
          end else begin
            mag = y - x;
            neg = sy;
          end
          den = da * dc;
        end
        CMD_MUL: begin
          mag = ma * mc;
          den = da * dc;
          neg = sa != sc;
        end
        default: begin
          mag = ma * dc;
          den = da * mc;
          neg = sa != sc;
        end
      endcase
      if (mag == 0) begin
        r.den = 31'd1;
        return r;
      end
      a = mag;
      b = den;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      g   = a;
      mag = mag / g;
      den = den / g;
      if (den > half - 1 || (neg ? (mag > half) : (mag > half - 1))) begin
        r.status = ST_OVERFLOW;
        return r;
      end
      r.num = 32'(neg ? (64'd0 - mag) : mag);
      r.den = 31'(den);
      return r;
    endfunction

    function void note_operands(cmd_t cmd, logic [31:0] ln, logic [31:0] ld,
                                logic [31:0] rn, logic [31:0] rd);
      pending.push_back(reduce(cmd, ln, ld, rn, rd));
    endfunction

    function void check_result(logic [31:0] num, logic [30:0] den, logic [1:0] st);
      fraction_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result num=%0d den=%0d status=%0d",
                 $time, $signed(num), den, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (num !== e.num) begin
        $display("%0t: result_num expected %0d actual %0d", $time, e.num, $signed(num));
        errors++;
      end
      if (den !== e.den) begin
        $display("%0t: result_den expected %0d actual %0d", $time, e.den, den);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  rau_in_if  in_ch();
  rau_out_if out_ch();

  fraction_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;

  rational_arithmetic_unit_core #(.VALUE_WIDTH(VW)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // beat monitors and idle watchdog
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_operands(cmd_t'(in_ch.command), in_ch.left_num, in_ch.left_den,
                       in_ch.right_num, in_ch.right_den);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.result_num, out_ch.result_den, out_ch.status);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_operands(cmd_t cmd, logic [31:0] ln, logic [31:0] ld,
                               logic [31:0] rn, logic [31:0] rd);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.command   = cmd;
    in_ch.left_num  = ln;
    in_ch.left_den  = ld;
    in_ch.right_num = rn;
    in_ch.right_den = rd;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    go_quiet();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value(bit nonzero);
    logic [31:0] v;
    case ($urandom_range(5))
      0, 1, 2: v = 32'($signed($urandom_range(200)) - 100);
      3:       v = $urandom();
      4:       v = 32'($signed($urandom_range(131070)) - 65535);
      default: begin
        case ($urandom_range(4))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'hffff_ffff;
          3:       v = 32'd1;
          default: v = 32'h0;
        endcase
      end
    endcase
    if (nonzero && v == 0) v = 32'd1;
    return v;
  endfunction

  task automatic random_beat();
    cmd_t        cmd;
    bit          dz;
    logic [31:0] ld, rd;
    cmd = cmd_t'($urandom_range(3));
    dz  = ($urandom_range(19) == 0);
    ld  = pick_value(!dz);
    rd  = pick_value(!dz);
    send_operands(cmd, pick_value(0), ld, pick_value(0), rd);
  endtask

  initial begin
    int unsigned phase;
    sb               = new();
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = '0;
    in_ch.left_num   = '0;
    in_ch.left_den   = '0;
    in_ch.right_num  = '0;
    in_ch.right_den  = '0;
    out_ch.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    quiet_cycles     = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: errors, extremes, every operation
    send_operands(CMD_ADD, 32'd1, 32'd0, 32'd1, 32'd2);
    send_operands(CMD_DIV, 32'd1, 32'd3, 32'd5, 32'd0);
    send_operands(CMD_DIV, 32'd1, 32'd3, 32'd0, 32'd7);
    send_operands(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_operands(CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_operands(CMD_SUB, 32'd1, 32'd3, 32'd1, 32'd2);
    send_operands(CMD_MUL, -32'sd2, 32'd3, 32'd3, -32'sd4);
    send_operands(CMD_DIV, 32'd2, -32'sd3, -32'sd4, 32'd9);
    send_operands(CMD_MUL, 32'd0, -32'sd5, 32'd7, 32'd3);
    send_operands(CMD_MUL, 32'h8000_0000, 32'hffff_ffff, 32'd1, 32'd1);
    send_operands(CMD_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_operands(CMD_DIV, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
    send_operands(CMD_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
    send_operands(CMD_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_operands(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_operands(CMD_MUL, 32'd1, 32'h7fff_ffff, 32'd1, 32'd2);
    send_operands(CMD_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_operands(CMD_SUB, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_operands(CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h8000_0000);
    send_operands(CMD_DIV, 32'h5555_5555, 32'haaaa_aaaa, 32'h7fff_ffff, 32'h8000_0001);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      repeat (220) random_beat();
      // sender holds off until every result is back
      wait_drained();
    end

    go_quiet();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (Drain) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
